// ===== sv/itoa_pkg.sv =====
// Package with the constants, transaction types and the digit character helper of the radix converter.
`default_nettype none
package itoa_pkg;

    localparam int VALUE_BITS = 16;
    localparam int MAX_PAD    = 32;
    localparam int BASE_W     = 5;
    localparam int PAD_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 6;
    localparam int COUNT_W    = $clog2(VALUE_BITS + 1);
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int REM_W      = 4;
    localparam int STEP_BITS  = 4;
    localparam int DIV_CYCLES = VALUE_BITS / STEP_BITS;
    localparam int STEP_CNT_W = $clog2(DIV_CYCLES);

    localparam logic [BASE_W-1:0] MIN_RADIX = BASE_W'(2);
    localparam logic [BASE_W-1:0] MAX_RADIX = BASE_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [REM_W-1:0]  DECIMAL_DIGITS = REM_W'(10);

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] number;
        logic [BASE_W-1:0]            base;
        logic [PAD_W-1:0]             min_digits;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              is_final;
        logic [LEN_W-1:0]  total_length;
    } t_out;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] digit);
        logic [CHAR_W-1:0] ch;
        if (digit < DECIMAL_DIGITS) begin
            ch = CHAR_ZERO + CHAR_W'(digit);
        end else begin
            ch = CHAR_UPPER_A + CHAR_W'(digit - DECIMAL_DIGITS);
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

// ===== sv/int_to_ascii_radix_padded.sv =====
// Top level of the signed integer to ASCII converter with radix and zero padding.
`default_nettype none
// One transaction converts a signed 16-bit value into ASCII characters, most significant
// first: an optional '-', zero padding up to the minimum digit count (at most 32), then the
// digits in 0-9A-F. The radix is clamped to 2..16. Digits come from a shared divider that
// retires four quotient bits per cycle; then one character is sent per cycle. A new start
// is taken only once the previous transaction is done and busy is low. Results appear for
// one cycle on o_result with o_strobe high and cannot be stalled by the receiver.
module int_to_ascii_radix_padded (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire itoa_pkg::t_in i_item,
    output logic               o_strobe,
    output itoa_pkg::t_out     o_result
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_SIGN  = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_DIGIT = 3'd4;

    logic [2:0]                          r_state, n_state;
    logic [itoa_pkg::VALUE_BITS-1:0]     r_dividend, n_dividend;
    logic [itoa_pkg::REM_W-1:0]          r_rem, n_rem;
    logic [itoa_pkg::BASE_W-1:0]         r_radix, n_radix;
    logic [itoa_pkg::PAD_W-1:0]          r_minpad, n_minpad;
    logic [itoa_pkg::PAD_W-1:0]          r_pad, n_pad;
    logic [itoa_pkg::COUNT_W-1:0]        r_digit_count, n_digit_count;
    logic [itoa_pkg::STEP_CNT_W-1:0]     r_step, n_step;
    logic                                r_neg, n_neg;
    logic [itoa_pkg::LEN_W-1:0]          r_total, n_total;
    logic                                r_strobe, n_strobe;
    itoa_pkg::t_out                      r_result, n_result;
    logic [itoa_pkg::REM_W-1:0]          r_digit_store [itoa_pkg::VALUE_BITS];

    logic [itoa_pkg::VALUE_BITS-1:0]     raw;
    logic [itoa_pkg::VALUE_BITS-1:0]     div_quo;
    logic [itoa_pkg::REM_W-1:0]          div_rem;
    logic [itoa_pkg::REM_W:0]            trial;
    logic [itoa_pkg::COUNT_W-1:0]        count_next;
    logic [itoa_pkg::PAD_W-1:0]          pad_next;
    logic [itoa_pkg::COUNT_W-1:0]        read_count;
    logic                                store_digit;

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;
    assign raw      = unsigned'(i_item.number);

    always_comb begin
        div_rem = r_rem;
        div_quo = r_dividend;
        trial   = '0;
        for (int k = 0; k < itoa_pkg::STEP_BITS; k++) begin
            trial   = {div_rem, div_quo[itoa_pkg::VALUE_BITS-1]};
            div_quo = {div_quo[itoa_pkg::VALUE_BITS-2:0], 1'b0};
            if (trial >= r_radix) begin
                trial      = trial - r_radix;
                div_quo[0] = 1'b1;
            end
            div_rem = trial[itoa_pkg::REM_W-1:0];
        end
    end

    assign count_next = r_digit_count + itoa_pkg::COUNT_W'(1);
    assign pad_next   = (r_minpad > itoa_pkg::PAD_W'(count_next))
                      ? r_minpad - itoa_pkg::PAD_W'(count_next) : '0;
    assign read_count = r_digit_count - itoa_pkg::COUNT_W'(1);
    assign store_digit = (r_state == S_DIV)
                       && (r_step == itoa_pkg::STEP_CNT_W'(itoa_pkg::DIV_CYCLES - 1));

    always_comb begin
        n_state       = r_state;
        n_dividend    = r_dividend;
        n_rem         = r_rem;
        n_radix       = r_radix;
        n_minpad      = r_minpad;
        n_pad         = r_pad;
        n_digit_count = r_digit_count;
        n_step        = r_step;
        n_neg         = r_neg;
        n_total       = r_total;
        n_strobe      = 1'b0;
        n_result      = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_neg = raw[itoa_pkg::VALUE_BITS-1];
                    n_dividend = n_neg ? (~raw + itoa_pkg::VALUE_BITS'(1)) : raw;
                    if (i_item.base < itoa_pkg::MIN_RADIX) begin
                        n_radix = itoa_pkg::MIN_RADIX;
                    end else if (i_item.base > itoa_pkg::MAX_RADIX) begin
                        n_radix = itoa_pkg::MAX_RADIX;
                    end else begin
                        n_radix = i_item.base;
                    end
                    if (i_item.min_digits > itoa_pkg::PAD_W'(itoa_pkg::MAX_PAD)) begin
                        n_minpad = itoa_pkg::PAD_W'(itoa_pkg::MAX_PAD);
                    end else begin
                        n_minpad = i_item.min_digits;
                    end
                    n_rem         = '0;
                    n_step        = '0;
                    n_digit_count = '0;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                n_dividend = div_quo;
                n_rem      = div_rem;
                n_step     = r_step + itoa_pkg::STEP_CNT_W'(1);
                if (store_digit) begin
                    n_digit_count = count_next;
                    n_rem         = '0;
                    n_step        = '0;
                    if (div_quo == '0) begin
                        n_pad   = pad_next;
                        n_total = itoa_pkg::LEN_W'(r_neg) + itoa_pkg::LEN_W'(pad_next)
                                + itoa_pkg::LEN_W'(count_next);
                        if (r_neg) begin
                            n_state = S_SIGN;
                        end else if (pad_next != '0) begin
                            n_state = S_PAD;
                        end else begin
                            n_state = S_DIGIT;
                        end
                    end
                end
            end
            S_SIGN: begin
                n_strobe                = 1'b1;
                n_result.character      = itoa_pkg::CHAR_MINUS;
                n_result.is_final       = 1'b0;
                n_result.total_length   = '0;
                n_state = (r_pad != '0) ? S_PAD : S_DIGIT;
            end
            S_PAD: begin
                n_strobe                = 1'b1;
                n_result.character      = itoa_pkg::CHAR_ZERO;
                n_result.is_final       = 1'b0;
                n_result.total_length   = '0;
                n_pad                   = r_pad - itoa_pkg::PAD_W'(1);
                if (r_pad == itoa_pkg::PAD_W'(1)) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                n_strobe           = 1'b1;
                n_result.character =
                    itoa_pkg::digit_char(r_digit_store[read_count[itoa_pkg::IDX_W-1:0]]);
                n_digit_count      = read_count;
                if (r_digit_count == itoa_pkg::COUNT_W'(1)) begin
                    n_result.is_final     = 1'b1;
                    n_result.total_length = r_total;
                    n_state               = S_IDLE;
                end else begin
                    n_result.is_final     = 1'b0;
                    n_result.total_length = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_strobe      <= 1'b0;
            r_step        <= '0;
            r_digit_count <= '0;
            r_pad         <= '0;
            r_neg         <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_strobe      <= n_strobe;
            r_step        <= n_step;
            r_digit_count <= n_digit_count;
            r_pad         <= n_pad;
            r_neg         <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dividend <= n_dividend;
        r_rem      <= n_rem;
        r_radix    <= n_radix;
        r_minpad   <= n_minpad;
        r_total    <= n_total;
        r_result   <= n_result;
        if (store_digit) begin
            r_digit_store[r_digit_count[itoa_pkg::IDX_W-1:0]] <= div_rem;
        end
    end

endmodule
`default_nettype wire
